// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/emac_pkg.sv =====
// ----------------------------------------------------------------------------
// emac_pkg
// Types and constants of the eye monitor align calibration sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package emac_pkg;

    // Sequencer steps, coded as reported on step_phase
    typedef enum logic [2:0] {
        SEQ_IDLE  = 3'd0,
        SEQ_OFST  = 3'd1,
        SEQ_CHIGH = 3'd2,
        SEQ_CLOW  = 3'd3,
        SEQ_FINE  = 3'd4,
        SEQ_DONE  = 3'd5
    } emac_seq_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_RUN_OFST = 2'd0;
    localparam logic [1:0] CFG_SPEED    = 2'd1;
    localparam logic [1:0] CFG_UI_CODES = 2'd2;
    localparam logic [1:0] CFG_RATE_SEL = 2'd3;

    // Pass flag bit positions
    localparam int F_DAC    = 0;
    localparam int F_COARSE = 1;
    localparam int F_FEDGE  = 2;
    localparam int F_DATA   = 3;

    localparam logic [3:0]  OFST_MID      = 4'h8;
    localparam logic [3:0]  OFST_MAX      = 4'hf;
    localparam logic [3:0]  PAT_A         = 4'ha;
    localparam logic [3:0]  PAT_B         = 4'h5;
    localparam logic [15:0] COARSE_LIM_LO = 16'd20;
    localparam logic [15:0] COARSE_LIM_HI = 16'd128;
    localparam logic [15:0] FINE_MULT     = 16'd68;

    typedef struct packed {
        logic       run_offset_cal;
        logic [2:0] rx_speed_div;
        logic [7:0] ui_pi_codes;
        logic       rate_slot;
    } emac_cfg_t;

    // Sequencer state apart from the phase code
    typedef struct packed {
        emac_seq_t   seq;
        logic [3:0]  offset_code;
        logic [3:0]  dir_history;
        logic [15:0] sample_count;
        logic        pd_select;
        logic [3:0]  pass_flags;
        logic        done_flag;
    } emac_state_t;

endpackage

// ===== sv/eye_monitor_align_calibration.sv =====
// ----------------------------------------------------------------------------
// eye_monitor_align_calibration
// Align calibration sequencer: offset DAC, coarse and fine phase search.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one beat per comparator sample: tuser is the mode (1 starts
//   a new run, 0 is a sample) and tdata[0] the comparator output. Each
//   accepted beat produces exactly one m_axis beat with the settings and
//   status after that sample (DAC code, phase code and strobe, pd select,
//   pass flags, done, step).
//   The cfg channel writes a register (index, data); cfg_ready is always high
//   and writes are meant for idle periods only.
//   The result beat appears in the cycle after its input beat is accepted.
//   Throughput is one beat per cycle unless m_axis stalls: the whole step is
//   one pass of logic from the sequencer state registers into the result register.
//   While m_axis is stalled the result register holds and s_axis_tready
//   drops; a beat is still taken in the cycle the result is accepted.
//   Reset clears the sequencer to idle, DAC code to mid scale, flags and
//   stored phases to zero and the registers to their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module eye_monitor_align_calibration #(
    parameter int COARSE_STEP = 8,
    parameter int PHASE_WIDTH = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    // input stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [0] cmp_out
    input  logic                s_axis_tuser,   // [0] mode
    // result stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // ofst_dac, ofst_cal_en, phase_code, phase_strobe, pd_sel, dac_pass,
    // coarse_pass, fine_edge_pass, data_pass, done_res, step_phase
    output logic [((15 + PHASE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    localparam int RES_W = 15 + PHASE_WIDTH;
    localparam int OUT_W = ((RES_W + 7) / 8) * 8;

    emac_pkg::emac_cfg_t    cfg_reg;
    emac_pkg::emac_state_t  st_reg;
    emac_pkg::emac_state_t  st_next;
    logic [PHASE_WIDTH-1:0] phase_reg;
    logic [PHASE_WIDTH-1:0] phase_next;
    logic [PHASE_WIDTH-1:0] saved_rate0_reg;
    logic [PHASE_WIDTH-1:0] saved_rate1_reg;
    logic                   strobe;
    logic                   save_en;
    logic                   ofst_cal_en;
    logic [2:0]             step_code;
    logic                   in_accept;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       res_reg;
    logic [OUT_W-1:0]       res_next;
    logic [PHASE_WIDTH-1:0] res_phase;
    logic                   res_strobe;
    logic                   start_beat;
    logic                   ignored_beat;

    assign cfg_ready     = 1'b1;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = res_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.run_offset_cal <= 1'b0;
            cfg_reg.rx_speed_div   <= 3'd0;
            cfg_reg.ui_pi_codes    <= 8'd1;
            cfg_reg.rate_slot      <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                emac_pkg::CFG_RUN_OFST: cfg_reg.run_offset_cal <= cfg_data[0];
                emac_pkg::CFG_SPEED:    cfg_reg.rx_speed_div   <= cfg_data[2:0];
                emac_pkg::CFG_UI_CODES: cfg_reg.ui_pi_codes    <= cfg_data;
                emac_pkg::CFG_RATE_SEL: cfg_reg.rate_slot      <= cfg_data[0];
                default:                cfg_reg                <= cfg_reg;
            endcase
        end
    end

    emac_step #(
        .COARSE_STEP (COARSE_STEP),
        .PHASE_WIDTH (PHASE_WIDTH)
    ) u_step (
        .mode        (s_axis_tuser),
        .cmp_out     (s_axis_tdata[0]),
        .cfg         (cfg_reg),
        .st_q        (st_reg),
        .ph_q        (phase_reg),
        .st_d        (st_next),
        .ph_d        (phase_next),
        .strobe      (strobe),
        .save_en     (save_en),
        .ofst_cal_en (ofst_cal_en),
        .step_code   (step_code)
    );

    // Sequencer state, advanced once per input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.seq          <= emac_pkg::SEQ_IDLE;
            st_reg.offset_code  <= emac_pkg::OFST_MID;
            st_reg.dir_history  <= '0;
            st_reg.sample_count <= '0;
            st_reg.pd_select    <= 1'b0;
            st_reg.pass_flags   <= '0;
            st_reg.done_flag    <= 1'b0;
            phase_reg           <= '0;
            saved_rate0_reg     <= '0;
            saved_rate1_reg     <= '0;
        end
        else if (in_accept)
        begin
            st_reg    <= st_next;
            phase_reg <= phase_next;
            if (save_en && cfg_reg.rate_slot)
            begin
                saved_rate1_reg <= phase_next;
            end
            if (save_en && !cfg_reg.rate_slot)
            begin
                saved_rate0_reg <= phase_next;
            end
        end
    end

    // Result packing
    always_comb
    begin
        res_next = OUT_W'({
            step_code,
            st_next.done_flag,
            st_next.pass_flags[emac_pkg::F_DATA],
            st_next.pass_flags[emac_pkg::F_FEDGE],
            st_next.pass_flags[emac_pkg::F_COARSE],
            st_next.pass_flags[emac_pkg::F_DAC],
            st_next.pd_select,
            strobe,
            phase_next,
            ofst_cal_en,
            st_next.offset_code
        });
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            res_reg <= res_next;
        end
    end

    // Checks
    assign res_phase    = res_reg[4 + PHASE_WIDTH:5];
    assign res_strobe   = res_reg[5 + PHASE_WIDTH];
    assign start_beat   = in_accept && s_axis_tuser;
    assign ignored_beat = in_accept && !s_axis_tuser &&
                          (st_reg.seq == emac_pkg::SEQ_IDLE ||
                           st_reg.seq == emac_pkg::SEQ_DONE);

    `ASSERT_IMPLIES(a_done_flag, st_reg.seq == emac_pkg::SEQ_DONE, st_reg.done_flag)
    `ASSERT_NEXT(a_start_phase, start_beat, m_axis_tvalid && (res_phase == '0) && !res_strobe)
    `ASSERT_NEXT(a_idle_hold, ignored_beat, $stable(phase_reg) && !res_strobe)

endmodule

// ===== sv/emac_step.sv =====
// ----------------------------------------------------------------------------
// emac_step
// Next-state logic of the sequencer for one comparator beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module emac_step #(
    parameter int COARSE_STEP = 8,
    parameter int PHASE_WIDTH = 7
) (
    input  logic                    mode,
    input  logic                    cmp_out,
    input  emac_pkg::emac_cfg_t     cfg,
    input  emac_pkg::emac_state_t   st_q,
    input  logic [PHASE_WIDTH-1:0]  ph_q,
    output emac_pkg::emac_state_t   st_d,
    output logic [PHASE_WIDTH-1:0]  ph_d,
    output logic                    strobe,
    output logic                    save_en,
    output logic                    ofst_cal_en,
    output logic [2:0]              step_code
);

    localparam logic [PHASE_WIDTH-1:0] PH_STEP = PHASE_WIDTH'(COARSE_STEP);
    localparam logic [PHASE_WIDTH-1:0] PH_ONE  = PHASE_WIDTH'(1);

    logic [15:0] coarse_lim;
    logic [15:0] fine_lim;

    assign coarse_lim = (cfg.rx_speed_div == 3'd0) ? emac_pkg::COARSE_LIM_LO
                                                   : emac_pkg::COARSE_LIM_HI;
    assign fine_lim   = 16'(cfg.ui_pi_codes) * emac_pkg::FINE_MULT;

    // Next state
    always_comb
    begin
        logic stop;
        stop    = 1'b0;
        st_d    = st_q;
        ph_d    = ph_q;
        strobe  = 1'b0;
        save_en = 1'b0;
        if (mode)
        begin
            // start beat: clear flags, enter offset or coarse step
            st_d.done_flag    = 1'b0;
            st_d.pass_flags   = '0;
            st_d.dir_history  = '0;
            st_d.pd_select    = 1'b0;
            ph_d              = '0;
            if (cfg.run_offset_cal)
            begin
                st_d.offset_code = emac_pkg::OFST_MID;
                st_d.seq         = emac_pkg::SEQ_OFST;
            end
            else
            begin
                st_d.sample_count = '0;
                st_d.seq          = emac_pkg::SEQ_CHIGH;
            end
        end
        else
        begin
            case (st_q.seq)
                emac_pkg::SEQ_OFST:
                begin
                    if (cmp_out)
                    begin
                        st_d.offset_code = st_q.offset_code + 4'd1;
                        st_d.dir_history = {st_q.dir_history[2:0], 1'b1};
                    end
                    else
                    begin
                        st_d.offset_code = st_q.offset_code - 4'd1;
                        st_d.dir_history = {st_q.dir_history[2:0], 1'b0};
                    end
                    if (st_d.dir_history == emac_pkg::PAT_A ||
                        st_d.dir_history == emac_pkg::PAT_B)
                    begin
                        st_d.pass_flags[emac_pkg::F_DAC] = 1'b1;
                        stop = 1'b1;
                    end
                    else if (st_d.offset_code == 4'd0 ||
                             st_d.offset_code == emac_pkg::OFST_MAX)
                    begin
                        // rail hit: back to mid code
                        st_d.offset_code = emac_pkg::OFST_MID;
                        stop = 1'b1;
                    end
                    if (stop)
                    begin
                        st_d.sample_count = '0;
                        st_d.dir_history  = '0;
                        st_d.pd_select    = 1'b0;
                        ph_d              = '0;
                        st_d.seq          = emac_pkg::SEQ_CHIGH;
                    end
                end
                emac_pkg::SEQ_CHIGH:
                begin
                    st_d.sample_count = st_q.sample_count + 16'd1;
                    if (!cmp_out)
                    begin
                        st_d.dir_history = '0;
                        st_d.seq         = emac_pkg::SEQ_CLOW;
                    end
                    else
                    begin
                        st_d.dir_history = 4'd1;
                        ph_d   = ph_q + PH_STEP;
                        strobe = 1'b1;
                        if (st_d.sample_count >= coarse_lim)
                        begin
                            st_d.seq = emac_pkg::SEQ_CLOW;
                        end
                    end
                end
                emac_pkg::SEQ_CLOW:
                begin
                    st_d.sample_count = st_q.sample_count + 16'd1;
                    if (cmp_out)
                    begin
                        if (!st_q.dir_history[0])
                        begin
                            st_d.pass_flags[emac_pkg::F_COARSE] = 1'b1;
                            st_d.dir_history  = '0;
                            st_d.sample_count = '0;
                            st_d.seq          = emac_pkg::SEQ_FINE;
                        end
                        else
                        begin
                            stop = 1'b1;
                        end
                    end
                    else
                    begin
                        ph_d   = ph_q + PH_STEP;
                        strobe = 1'b1;
                        if (st_d.sample_count >= coarse_lim)
                        begin
                            stop = 1'b1;
                        end
                    end
                    if (stop)
                    begin
                        save_en        = 1'b1;
                        st_d.pd_select = 1'b0;
                        st_d.done_flag = 1'b1;
                        st_d.seq       = emac_pkg::SEQ_DONE;
                    end
                end
                emac_pkg::SEQ_FINE:
                begin
                    if (!cmp_out)
                    begin
                        ph_d             = ph_q + PH_ONE;
                        st_d.dir_history = {st_q.dir_history[2:0], 1'b1};
                    end
                    else
                    begin
                        ph_d             = ph_q - PH_ONE;
                        st_d.dir_history = {st_q.dir_history[2:0], 1'b0};
                    end
                    strobe = 1'b1;
                    if (st_d.dir_history == emac_pkg::PAT_A ||
                        st_d.dir_history == emac_pkg::PAT_B)
                    begin
                        if (st_q.pd_select)
                        begin
                            st_d.pass_flags[emac_pkg::F_DATA] = 1'b1;
                            stop = 1'b1;
                        end
                        else
                        begin
                            // edge lock found, move on to data clock
                            st_d.pass_flags[emac_pkg::F_FEDGE] = 1'b1;
                            st_d.pd_select   = 1'b1;
                            st_d.dir_history = '0;
                        end
                    end
                    if (!stop)
                    begin
                        if (st_q.sample_count < fine_lim)
                        begin
                            st_d.sample_count = st_q.sample_count + 16'd1;
                        end
                        else
                        begin
                            stop = 1'b1;
                        end
                    end
                    if (stop)
                    begin
                        save_en        = 1'b1;
                        st_d.pd_select = 1'b0;
                        st_d.done_flag = 1'b1;
                        st_d.seq       = emac_pkg::SEQ_DONE;
                    end
                end
                default:
                begin
                    // idle or done: samples are ignored
                end
            endcase
        end
    end

    // Status outputs
    always_comb
    begin
        ofst_cal_en = (st_d.seq == emac_pkg::SEQ_OFST);
        step_code   = 3'(st_d.seq);
    end

endmodule
